// ===== src/aeds_pkg.sv =====
// shared types, constants and reset values for the armed edge delayed strobe
`default_nettype none

package aeds_pkg;

  // counter width default and configuration port geometry
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_INDEX_W     = 8;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DELAY       = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_STROBE      = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_EDGE        = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_READY_DELAY = CFG_INDEX_W'(3);

  // register reset values
  localparam logic [15:0] DELAY_RST       = 16'd100;
  localparam logic [15:0] STROBE_RST      = 16'd200;
  localparam logic        EDGE_RST        = 1'b1;
  localparam logic [15:0] READY_DELAY_RST = 16'd300;

  // largest legal strobe or ready delay plus one; this code is invalid for those registers
  localparam logic [15:0] LIMIT_VALUE = 16'hFFFF;

  // delay / strobe phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_DELAY  = 3'b010,
    PH_STROBE = 3'b100
  } phase_t;

  // configuration seen by the core
  typedef struct packed {
    logic [15:0] delay_ticks;
    logic [15:0] strobe_ticks;
    logic        edge_select;
    logic [15:0] ready_delay_ticks;
    logic        bad;
    logic        clear;
  } cfg_t;

  // one result word
  typedef struct packed {
    logic strobe_res;
    logic config_error;
    logic capture_armed;
  } res_t;

endpackage

`default_nettype wire

// ===== src/aeds_if.sv =====
// valid/ready channel interfaces for input and result words
`default_nettype none

interface aeds_in_if;
  logic valid;
  logic ready;
  logic trigger_level;
  logic arm_request;

  modport source (output valid, output trigger_level, output arm_request, input ready);
  modport sink (input valid, input trigger_level, input arm_request, output ready);
endinterface

interface aeds_out_if;
  logic valid;
  logic ready;
  logic strobe_res;
  logic config_error;
  logic capture_armed;

  modport source (output valid, output strobe_res, output config_error,
                  output capture_armed, input ready);
  modport sink (input valid, input strobe_res, input config_error,
                input capture_armed, output ready);
endinterface

`default_nettype wire

// ===== src/aeds_cfg.sv =====
// configuration registers and validity check
`default_nettype none

module aeds_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [aeds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [aeds_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output aeds_pkg::cfg_t                        cfg
);
  import aeds_pkg::*;

  logic [15:0] delay_r;
  logic [15:0] strobe_r;
  logic        edge_r;
  logic [15:0] ready_delay_r;
  logic [16:0] span;
  logic        hit;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r       <= DELAY_RST;
      strobe_r      <= STROBE_RST;
      edge_r        <= EDGE_RST;
      ready_delay_r <= READY_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELAY:       delay_r       <= cfg_wdata[15:0];
        CFG_STROBE:      strobe_r      <= cfg_wdata[15:0];
        CFG_EDGE:        edge_r        <= cfg_wdata[0];
        CFG_READY_DELAY: ready_delay_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // any write to a known register disarms the core
  always_comb begin
    hit = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DELAY, CFG_STROBE, CFG_EDGE, CFG_READY_DELAY: hit = 1'b1;
        default: hit = 1'b0;
      endcase
    end
  end

  // delay plus strobe must not exceed the limit
  assign span = {1'b0, delay_r} + {1'b0, strobe_r};

  assign cfg.delay_ticks       = delay_r;
  assign cfg.strobe_ticks      = strobe_r;
  assign cfg.edge_select       = edge_r;
  assign cfg.ready_delay_ticks = ready_delay_r;
  assign cfg.clear             = hit;
  assign cfg.bad = (delay_r == 16'd0) || (strobe_r == LIMIT_VALUE) ||
                   (ready_delay_r == LIMIT_VALUE) || (span > {1'b0, LIMIT_VALUE});

endmodule

`default_nettype wire

// ===== src/aeds_core.sv =====
// per-tick state update: edge detect, ready delay, delay and strobe phases
`default_nettype none

module aeds_core #(
  parameter int COUNT_WIDTH = aeds_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire logic           trigger_level,
  input  wire logic           arm_request,
  input  wire aeds_pkg::cfg_t cfg,
  output aeds_pkg::res_t      res
);
  import aeds_pkg::*;

  logic                   last_r, last_nxt;
  logic [COUNT_WIDTH-1:0] ready_cnt_r, ready_cnt_nxt;
  logic                   pending_r, pending_nxt;
  logic                   armed_r, armed_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] phase_cnt_r, phase_cnt_nxt;

  logic [COUNT_WIDTH-1:0] dec;
  logic [COUNT_WIDTH-1:0] delay_ld;
  logic [COUNT_WIDTH-1:0] strobe_ld;
  logic                   trig_edge;

  assign delay_ld  = COUNT_WIDTH'(cfg.delay_ticks);
  assign strobe_ld = COUNT_WIDTH'(cfg.strobe_ticks);
  assign dec       = phase_cnt_r - COUNT_WIDTH'(1);
  assign trig_edge = cfg.edge_select ? (!last_r && trigger_level)
                                     : (last_r && !trigger_level);

  // next state for one tick
  always_comb begin
    last_nxt      = trigger_level;
    ready_cnt_nxt = ready_cnt_r;
    pending_nxt   = pending_r;
    armed_nxt     = armed_r;
    phase_nxt     = phase_r;
    phase_cnt_nxt = phase_cnt_r;
    if (cfg.bad) begin
      ready_cnt_nxt = '0;
      pending_nxt   = 1'b0;
      armed_nxt     = 1'b0;
      phase_nxt     = PH_IDLE;
      phase_cnt_nxt = '0;
    end else begin
      // advance delay / strobe
      case (phase_r)
        PH_DELAY: begin
          phase_cnt_nxt = dec;
          if (dec == '0) begin
            if (cfg.strobe_ticks != 16'd0) begin
              phase_nxt     = PH_STROBE;
              phase_cnt_nxt = strobe_ld;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_STROBE: begin
          phase_cnt_nxt = dec;
          if (dec == '0) phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt     = PH_IDLE;
          phase_cnt_nxt = '0;
        end
      endcase
      // armed capture taken by the trigger edge
      if (armed_r && trig_edge) begin
        armed_nxt     = 1'b0;
        phase_cnt_nxt = delay_ld;
        phase_nxt     = (delay_ld == '0) ? PH_IDLE : PH_DELAY;
      end
      // ready delay countdown
      if (pending_r) begin
        if (ready_cnt_r == '0) begin
          armed_nxt   = 1'b1;
          pending_nxt = 1'b0;
        end else begin
          ready_cnt_nxt = ready_cnt_r - COUNT_WIDTH'(1);
        end
      end
      if (arm_request) begin
        pending_nxt   = 1'b1;
        ready_cnt_nxt = COUNT_WIDTH'(cfg.ready_delay_ticks);
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= 1'b0;
      ready_cnt_r <= '0;
      pending_r   <= 1'b0;
      armed_r     <= 1'b0;
      phase_r     <= PH_IDLE;
      phase_cnt_r <= '0;
    end else if (cfg.clear) begin
      ready_cnt_r <= '0;
      pending_r   <= 1'b0;
      armed_r     <= 1'b0;
      phase_r     <= PH_IDLE;
      phase_cnt_r <= '0;
    end else if (step) begin
      last_r      <= last_nxt;
      ready_cnt_r <= ready_cnt_nxt;
      pending_r   <= pending_nxt;
      armed_r     <= armed_nxt;
      phase_r     <= phase_nxt;
      phase_cnt_r <= phase_cnt_nxt;
    end
  end

  // result word shows the state after the tick
  assign res.strobe_res    = (phase_nxt == PH_STROBE);
  assign res.config_error  = cfg.bad;
  assign res.capture_armed = armed_nxt;

  // checks
  a_armed_valid_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> !cfg.bad) else $error("armed with invalid configuration");
  a_busy_valid_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> !cfg.bad) else $error("phase running with invalid configuration");
  a_delay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DELAY) |-> (phase_cnt_r != '0)) else $error("delay phase with zero count");
  a_clear_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.clear |=> (!armed_r && !pending_r && (phase_r == PH_IDLE)))
    else $error("register write did not disarm");
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r)) else $error("phase not one-hot");

endmodule

`default_nettype wire

// ===== src/armed_edge_delayed_strobe.sv =====
// Armed edge-triggered delayed strobe, top level.
// An accepted word passes the input register, then the result register, which
// holds its result word; throughput is one word per cycle while the output is not stalled.
// The tick state update is a single pass of logic between the two registers.
// Reset (rst_n low, synchronous) loads register defaults 100/200/1/300, clears
// all state and empties both registers.
`default_nettype none

module armed_edge_delayed_strobe #(
  parameter int COUNT_WIDTH = aeds_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  aeds_in_if.sink                               in_ch,
  aeds_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [aeds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [aeds_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import aeds_pkg::*;

  logic  in_vld_r;
  logic  in_lvl_r;
  logic  in_req_r;
  logic  out_vld_r;
  res_t  out_r;
  logic  step;
  cfg_t  cfg;
  res_t  res;

  // a tick is processed when the result register is free or being drained
  assign step         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || step;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_lvl_r <= in_ch.trigger_level;
      in_req_r <= in_ch.arm_request;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.strobe_res    = out_r.strobe_res;
  assign out_ch.config_error  = out_r.config_error;
  assign out_ch.capture_armed = out_r.capture_armed;

  // configuration registers
  aeds_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // tick state update
  aeds_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .trigger_level (in_lvl_r),
    .arm_request   (in_req_r),
    .cfg           (cfg),
    .res           (res)
  );

endmodule

`default_nettype wire

// ===== verif/armed_edge_delayed_strobe_tb.sv =====
// testbench for the armed edge delayed strobe: directed table, random ticks, scoreboard
`timescale 1ns / 100ps

module armed_edge_delayed_strobe_tb;
  import aeds_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int MODE_COUNT    = 3;
  localparam int PHASES        = 6;
  localparam int WORDS_PER_PH  = 90;
  localparam int MAX_REPORTS   = 10;

  // indexes past the last register, writes there are dropped
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] CFG_TOP   = '1;

  // result words that can be typed in directly
  localparam res_t RES_QUIET   = 3'b000;
  localparam res_t RES_CFG_ERR = 3'b010;

  typedef enum logic {
    ROW_WORD,
    ROW_REG
  } row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   lvl;
    logic                   req;
    logic                   typed;
    res_t                   want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  aeds_in_if  in_ch ();
  aeds_out_if out_ch ();

  armed_edge_delayed_strobe DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow registers and tick state of the strobe generator
  logic [15:0] sh_delay;
  logic [15:0] sh_strobe;
  logic        sh_rising;
  logic [15:0] sh_ready;
  logic        prev_trig;
  logic [15:0] arm_wait_cnt;
  logic        arm_wait;
  logic        capt_armed;
  phase_t      ph;
  logic [15:0] ph_cnt;

  res_t pending_res[$];
  res_t got_res;
  res_t want_res;
  int   mismatches = 0;
  int   cycles = 0;
  int   send_idle_pct;
  int   recv_idle_pct;

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // drop every capture, delay and pulse in progress
  function automatic void clear_capture();
    arm_wait_cnt = '0;
    arm_wait     = 1'b0;
    capt_armed   = 1'b0;
    ph           = PH_IDLE;
    ph_cnt       = '0;
  endfunction

  function automatic logic cfg_invalid();
    return (sh_delay == '0) || (sh_strobe == LIMIT_VALUE) || (sh_ready == LIMIT_VALUE) ||
           ({1'b0, sh_delay} > ({1'b0, LIMIT_VALUE} - {1'b0, sh_strobe}));
  endfunction

  // register write as the block sees it; any known index disarms
  function automatic void cfg_store(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_DELAY:       sh_delay  = data;
      CFG_STROBE:      sh_strobe = data;
      CFG_EDGE:        sh_rising = data[0];
      CFG_READY_DELAY: sh_ready  = data;
      default:         return;
    endcase
    clear_capture();
  endfunction

  // one tick: phase advance, edge capture, ready delay, arm request
  function automatic res_t strobe_tick(input logic lvl, input logic req);
    logic bad;
    logic hit;
    res_t r;
    bad = cfg_invalid();
    hit = sh_rising ? (!prev_trig && lvl) : (prev_trig && !lvl);
    prev_trig = lvl;
    if (bad) begin
      clear_capture();
    end else begin
      case (ph)
        PH_DELAY: begin
          ph_cnt = ph_cnt - 16'd1;
          if (ph_cnt == '0) begin
            if (sh_strobe != '0) begin
              ph     = PH_STROBE;
              ph_cnt = sh_strobe;
            end else begin
              ph = PH_IDLE;
            end
          end
        end
        PH_STROBE: begin
          ph_cnt = ph_cnt - 16'd1;
          if (ph_cnt == '0) ph = PH_IDLE;
        end
        default: begin
          ph     = PH_IDLE;
          ph_cnt = '0;
        end
      endcase
      // an edge while armed restarts the delay even if busy
      if (capt_armed && hit) begin
        capt_armed = 1'b0;
        ph         = PH_DELAY;
        ph_cnt     = sh_delay;
        if (ph_cnt == '0) ph = PH_IDLE;
      end
      if (arm_wait) begin
        if (arm_wait_cnt == '0) begin
          capt_armed = 1'b1;
          arm_wait   = 1'b0;
        end else begin
          arm_wait_cnt = arm_wait_cnt - 16'd1;
        end
      end
      if (req) begin
        arm_wait     = 1'b1;
        arm_wait_cnt = sh_ready;
      end
    end
    r.strobe_res    = (ph == PH_STROBE);
    r.config_error  = bad;
    r.capture_armed = capt_armed;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", what);
  endtask

  // send one input word, predicting its result when it is taken
  task automatic send_word(input logic lvl, input logic req, input logic typed,
                           input res_t typed_res);
    res_t want;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.trigger_level = lvl;
    in_ch.arm_request   = req;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    want = strobe_tick(lvl, req);
    if (typed) want = typed_res;
    pending_res.push_back(want);
  endtask

  // register write once every result word is back
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_store(idx, data);
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // scoreboard
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_res.strobe_res    = out_ch.strobe_res;
      got_res.config_error  = out_ch.config_error;
      got_res.capture_armed = out_ch.capture_armed;
      if (pending_res.size() == 0) begin
        flag_mismatch($sformatf("unexpected result word %b", got_res));
      end else begin
        want_res = pending_res.pop_front();
        if (got_res.strobe_res !== want_res.strobe_res ||
            got_res.config_error !== want_res.config_error ||
            got_res.capture_armed !== want_res.capture_armed) begin
          flag_mismatch($sformatf(
            "result mismatch: strobe/err/armed expected %b%b%b got %b%b%b",
            want_res.strobe_res, want_res.config_error, want_res.capture_armed,
            got_res.strobe_res, got_res.config_error, got_res.capture_armed));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    plan_row_t   plan[$];
    logic        lvl;
    logic        req;
    logic        noisy;
    logic [15:0] d;
    logic [15:0] s;
    logic [15:0] e;
    logic [15:0] r;

    send_idle_pct       = 32;
    recv_idle_pct       = 82;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.trigger_level = 1'b0;
    in_ch.arm_request   = 1'b0;

    // shadow state after reset
    sh_delay  = DELAY_RST;
    sh_strobe = STROBE_RST;
    sh_rising = EDGE_RST;
    sh_ready  = READY_DELAY_RST;
    prev_trig = 1'b0;
    clear_capture();

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    plan = '{
      // quiet word straight out of reset
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b0, 1'b0, 1'b1, RES_QUIET},
      // short delay and pulse, arming with no ready delay
      '{ROW_REG, CFG_DELAY, 16'd2, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_REG, CFG_STROBE, 16'd3, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_REG, CFG_READY_DELAY, 16'd0, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b0, 1'b1, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b1, 1'b0, 1'b0, RES_QUIET},
      // re-arm while the delay runs, then another edge during the pulse
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b1, 1'b1, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b1, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b1, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b0, 1'b0, 1'b0, RES_QUIET},
      // falling edge with a zero length pulse
      '{ROW_REG, CFG_EDGE, 16'd0, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_REG, CFG_STROBE, 16'd0, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b1, 1'b1, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b1, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b0, 1'b0, 1'b0, RES_QUIET},
      // each invalid setting flags an error and ignores arming
      '{ROW_REG, CFG_DELAY, 16'd0, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b1, 1'b1, 1'b1, RES_CFG_ERR},
      '{ROW_REG, CFG_DELAY, 16'd2, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_REG, CFG_STROBE, LIMIT_VALUE, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b0, 1'b1, 1'b1, RES_CFG_ERR},
      '{ROW_REG, CFG_STROBE, 16'd65534, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b1, 1'b1, 1'b1, RES_CFG_ERR},
      '{ROW_REG, CFG_STROBE, 16'd0, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_REG, CFG_READY_DELAY, LIMIT_VALUE, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b0, 1'b1, 1'b1, RES_CFG_ERR},
      // largest valid delay and ready delay
      '{ROW_REG, CFG_DELAY, LIMIT_VALUE, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_REG, CFG_READY_DELAY, 16'd65534, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b1, 1'b1, 1'b1, RES_QUIET},
      // writes past the last register change nothing
      '{ROW_REG, CFG_SPARE, 16'd0, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_REG, CFG_TOP, 16'd0, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b0, 1'b1, 1'b1, RES_QUIET},
      // longest valid pulse behind the shortest delay
      '{ROW_REG, CFG_DELAY, 16'd1, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_REG, CFG_STROBE, 16'd65534, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_REG, CFG_READY_DELAY, 16'd0, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_REG, CFG_EDGE, 16'd1, 1'b0, 1'b0, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b0, 1'b1, 1'b0, RES_QUIET},
      '{ROW_WORD, CFG_DELAY, 16'd0, 1'b1, 1'b0, 1'b0, RES_QUIET}
    };

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        cfg_write(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].lvl, plan[i].req, plan[i].typed, plan[i].want);
      end
    end

    // random phases under each idling mode
    lvl = 1'b0;
    for (int m = 0; m < MODE_COUNT; m++) begin
      case (m)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 82;
        end
        1: begin
          send_idle_pct = 82;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int p = 0; p < PHASES; p++) begin
        // mostly short valid timings, some full range and some invalid
        d = 16'($urandom_range(1, 12));
        s = 16'($urandom_range(0, 10));
        r = 16'($urandom_range(0, 8));
        e = 16'($urandom);
        case ($urandom_range(9))
          0: begin
            d = 16'($urandom);
            s = 16'($urandom);
            r = 16'($urandom);
          end
          1: begin
            case ($urandom_range(3))
              0: d = '0;
              1: s = LIMIT_VALUE;
              2: r = LIMIT_VALUE;
              default: begin
                d = 16'($urandom_range(2, 65535));
                s = 16'($urandom_range(65536 - int'(d), 65534));
              end
            endcase
          end
          default: ;
        endcase
        cfg_write(CFG_DELAY, d);
        cfg_write(CFG_STROBE, s);
        cfg_write(CFG_EDGE, e);
        cfg_write(CFG_READY_DELAY, r);
        if ($urandom_range(3) == 0) begin
          cfg_write(CFG_INDEX_W'($urandom_range(4, 255)), 16'($urandom));
        end

        // held trigger levels with sparse arm requests, or plain noise
        noisy = ($urandom_range(4) == 0);
        for (int k = 0; k < WORDS_PER_PH; k++) begin
          if (noisy) begin
            lvl = 1'($urandom_range(1));
            req = 1'($urandom_range(1));
          end else begin
            if ($urandom_range(3) == 0) lvl = ~lvl;
            req = ($urandom_range(11) == 0);
          end
          send_word(lvl, req, 1'b0, RES_QUIET);
        end
      end
    end

    // drain and settle
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_res.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
